// File: design/tgc_pkg.sv
// shared types and constants for the touch gesture classifier
package tgc_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned GEST_W = 2;

    localparam logic [GEST_W-1:0] GEST_TAP = 2'd0;
    localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd1;
    localparam logic [GEST_W-1:0] GEST_LONG = 2'd2;

    localparam logic REG_LONG_PRESS = 1'b0;
    localparam logic REG_DOUBLE_CLICK = 1'b1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } tgc_cmd_t;

    typedef struct packed {
        logic ev_valid;
        logic pend_valid;
        logic out_free;
    } tgc_status_t;

endpackage

// File: design/touch_gesture_classifier.sv
// top level: tap, double click and long press detector for touch electrodes
// a poll is loaded, each electrode is visited in turn, then a flush state runs before ready again
// one electrode is evaluated per cycle, unless stalled, by a single shared compare datapath
// extra cycles only while a word must move into an output word not yet taken
// the first result word passes through the pending event register, then the output word register
// reset clears all electrode flags and loads 1000 ms long press and 300 ms window
module touch_gesture_classifier #(
    parameter int unsigned NUM_ELECTRODES = 6,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [tgc_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [NUM_ELECTRODES-1:0]           touch_mask,
    input  logic [TIME_BITS-1:0]                time_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [((NUM_ELECTRODES > 1) ? $clog2(NUM_ELECTRODES) : 1)-1:0] electrode,
    output logic [tgc_pkg::GEST_W-1:0]          gesture,
    output logic                                last_event
);

    localparam int unsigned IDX_BITS = (NUM_ELECTRODES > 1) ? $clog2(NUM_ELECTRODES) : 1;

    tgc_pkg::tgc_cmd_t    cmd;
    tgc_pkg::tgc_status_t status;
    logic [IDX_BITS-1:0]  idx;

    tgc_controller #(
        .NUM_ELECTRODES (NUM_ELECTRODES),
        .IDX_BITS       (IDX_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .idx      (idx)
    );

    tgc_datapath #(
        .NUM_ELECTRODES (NUM_ELECTRODES),
        .TIME_BITS      (TIME_BITS),
        .IDX_BITS       (IDX_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .touch_mask (touch_mask),
        .time_ms    (time_ms),
        .cmd        (cmd),
        .idx        (idx),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .electrode  (electrode),
        .gesture    (gesture),
        .last_event (last_event)
    );

endmodule

// File: design/tgc_datapath.sv
// per-electrode state, gesture evaluation, pending event and output word registers
module tgc_datapath #(
    parameter int unsigned NUM_ELECTRODES = 6,
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned IDX_BITS = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tgc_pkg::CFG_W-1:0]   cfg_data,
    input  logic [NUM_ELECTRODES-1:0]   touch_mask,
    input  logic [TIME_BITS-1:0]        time_ms,
    input  tgc_pkg::tgc_cmd_t           cmd,
    input  logic [IDX_BITS-1:0]         idx,
    output tgc_pkg::tgc_status_t        status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [IDX_BITS-1:0]         electrode,
    output logic [tgc_pkg::GEST_W-1:0]  gesture,
    output logic                        last_event
);

    logic [tgc_pkg::CFG_W-1:0]  long_press_reg;
    logic [tgc_pkg::CFG_W-1:0]  double_click_reg;
    logic [NUM_ELECTRODES-1:0]  mask_reg;
    logic [TIME_BITS-1:0]       now_reg;
    logic [NUM_ELECTRODES-1:0]  held_reg;
    logic [NUM_ELECTRODES-1:0]  long_rep_reg;
    logic [NUM_ELECTRODES-1:0]  tap_wait_reg;
    logic [TIME_BITS-1:0]       press_time_reg [NUM_ELECTRODES];
    logic [TIME_BITS-1:0]       tap_time_reg [NUM_ELECTRODES];
    logic                       pend_valid_reg;
    logic [IDX_BITS-1:0]        pend_elec_reg;
    logic [tgc_pkg::GEST_W-1:0] pend_gest_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [IDX_BITS-1:0]        out_elec_reg;
    logic [tgc_pkg::GEST_W-1:0] out_gest_reg;
    logic                       out_last_reg;

    logic                       touched;
    logic                       new_touch;
    logic                       release_now;
    logic                       lr1;
    logic [TIME_BITS-1:0]       start_time;
    logic [TIME_BITS-1:0]       el_press;
    logic [TIME_BITS-1:0]       el_tap;
    logic                       long_fire;
    logic                       lr2;
    logic                       tw1;
    logic                       dbl;
    logic                       start_tap;
    logic                       tw2;
    logic                       tap_fire;
    logic [tgc_pkg::GEST_W-1:0] ev_gest;
    logic                       ev_valid;
    logic                       out_free;
    logic                       push_mid;
    logic                       push;

    // one electrode per cycle while the walk is not stalled
    always_comb
    begin
        touched = mask_reg[idx];
        new_touch = touched & ~held_reg[idx];
        release_now = ~touched & held_reg[idx];
        lr1 = new_touch ? 1'b0 : long_rep_reg[idx];
        start_time = new_touch ? now_reg : press_time_reg[idx];
        el_press = now_reg - start_time;
        el_tap = now_reg - tap_time_reg[idx];
        long_fire = touched & ~lr1 & (el_press >= TIME_BITS'(long_press_reg));
        lr2 = lr1 | long_fire;
        tw1 = long_fire ? 1'b0 : tap_wait_reg[idx];
        dbl = release_now & ~lr2 & tw1 & (el_tap <= TIME_BITS'(double_click_reg));
        start_tap = release_now & ~lr2 & ~dbl;
        tw2 = dbl ? 1'b0 : (start_tap ? 1'b1 : tw1);
        tap_fire = tw2 & ~start_tap & (el_tap > TIME_BITS'(double_click_reg));
        ev_valid = long_fire | dbl | tap_fire;
        if (tap_fire)
        begin
            ev_gest = tgc_pkg::GEST_TAP;
        end
        else if (dbl)
        begin
            ev_gest = tgc_pkg::GEST_DOUBLE;
        end
        else
        begin
            ev_gest = tgc_pkg::GEST_LONG;
        end
    end

    assign out_free = ~out_valid_reg | out_ready;
    assign push_mid = cmd.step & ev_valid & pend_valid_reg;
    assign push = push_mid | cmd.flush;

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= tgc_pkg::LONG_PRESS_RESET;
            double_click_reg <= tgc_pkg::DOUBLE_CLICK_RESET;
            held_reg <= '0;
            long_rep_reg <= '0;
            tap_wait_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tgc_pkg::REG_LONG_PRESS:   long_press_reg <= cfg_data;
                    tgc_pkg::REG_DOUBLE_CLICK: double_click_reg <= cfg_data;
                    default:                   long_press_reg <= long_press_reg;
                endcase
            end
            if (cmd.step)
            begin
                held_reg[idx] <= touched;
                long_rep_reg[idx] <= lr2;
                tap_wait_reg[idx] <= tw2 & ~tap_fire;
            end
            if (cmd.step && ev_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush || cmd.load)
            begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg <= touch_mask;
            now_reg <= time_ms;
        end
        if (cmd.step)
        begin
            press_time_reg[idx] <= start_time;
            if (start_tap)
            begin
                tap_time_reg[idx] <= now_reg;
            end
        end
        if (cmd.step && ev_valid)
        begin
            pend_elec_reg <= idx;
            pend_gest_reg <= ev_gest;
        end
        if (push)
        begin
            out_elec_reg <= pend_elec_reg;
            out_gest_reg <= pend_gest_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign status.ev_valid = ev_valid;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign electrode = out_elec_reg;
    assign gesture = out_gest_reg;
    assign last_event = out_last_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("output word overwritten before it was taken");

    a_flush_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> pend_valid_reg)
        else $error("flush without a pending event");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.flush}))
        else $error("more than one command at once");

    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !pend_valid_reg)
        else $error("new poll loaded with an event still pending");
`endif

endmodule

// File: design/tgc_controller.sv
// sequencer that walks the electrodes of one poll and flushes the final event
module tgc_controller #(
    parameter int unsigned NUM_ELECTRODES = 6,
    parameter int unsigned IDX_BITS = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tgc_pkg::tgc_status_t  status,
    output tgc_pkg::tgc_cmd_t     cmd,
    output logic [IDX_BITS-1:0]   idx
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_VISIT = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_ELECTRODES - 1);

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [IDX_BITS-1:0] idx_reg;
    logic [IDX_BITS-1:0] idx_next;
    logic                stall;

    // a second event needs the output word free before the pending one moves out
    assign stall = status.ev_valid & status.pend_valid & ~status.out_free;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    state_next = S_VISIT;
                end
            end
            S_VISIT:
            begin
                if (!stall)
                begin
                    cmd.step = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign idx = idx_reg;

endmodule

// File: tb/sv/tb_touch_gesture_classifier.sv
// testbench for the touch gesture classifier: predicted event words checked under random handshakes
module tb_touch_gesture_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_EL = 6;
    localparam int unsigned T_BITS = 32;
    localparam int unsigned EL_W = (NUM_EL > 1) ? $clog2(NUM_EL) : 1;
    localparam int unsigned CFG_W = tgc_pkg::CFG_W;
    localparam int unsigned GEST_W = tgc_pkg::GEST_W;
    localparam int unsigned SETTLE_CYCLES = NUM_EL + 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [EL_W-1:0]   electrode;
        logic [GEST_W-1:0] gesture;
        logic              last_event;
    } gesture_word_t;

    class gesture_board;
        logic [CFG_W-1:0]  hold_ms;
        logic [CFG_W-1:0]  window_ms;
        bit                held [NUM_EL];
        bit                long_done [NUM_EL];
        bit                tap_armed [NUM_EL];
        logic [T_BITS-1:0] press_t [NUM_EL];
        logic [T_BITS-1:0] tap_t [NUM_EL];
        gesture_word_t     expected_words [$];
        int                mismatches;

        function void clear();
            hold_ms = tgc_pkg::LONG_PRESS_RESET;
            window_ms = tgc_pkg::DOUBLE_CLICK_RESET;
            for (int e = 0; e < NUM_EL; e++)
            begin
                held[e] = 1'b0;
                long_done[e] = 1'b0;
                tap_armed[e] = 1'b0;
                press_t[e] = '0;
                tap_t[e] = '0;
            end
            expected_words.delete();
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == tgc_pkg::REG_LONG_PRESS)
                hold_ms = value;
            else
                window_ms = value;
        endfunction

        function void note_poll(logic [NUM_EL-1:0] mask, logic [T_BITS-1:0] now);
            gesture_word_t     w;
            bit                fired;
            logic [GEST_W-1:0] g;
            int                count;
            count = 0;
            for (int e = 0; e < NUM_EL; e++)
            begin
                fired = 1'b0;
                g = tgc_pkg::GEST_TAP;
                if (mask[e] && !held[e])
                begin
                    held[e] = 1'b1;
                    press_t[e] = now;
                    long_done[e] = 1'b0;
                end
                if (mask[e] && !long_done[e] && (now - press_t[e]) >= T_BITS'(hold_ms))
                begin
                    long_done[e] = 1'b1;
                    tap_armed[e] = 1'b0;
                    fired = 1'b1;
                    g = tgc_pkg::GEST_LONG;
                end
                if (!mask[e] && held[e])
                begin
                    held[e] = 1'b0;
                    if (!long_done[e])
                    begin
                        if (tap_armed[e] && (now - tap_t[e]) <= T_BITS'(window_ms))
                        begin
                            tap_armed[e] = 1'b0;
                            fired = 1'b1;
                            g = tgc_pkg::GEST_DOUBLE;
                        end
                        else
                        begin
                            tap_armed[e] = 1'b1;
                            tap_t[e] = now;
                        end
                    end
                end
                if (tap_armed[e] && (now - tap_t[e]) > T_BITS'(window_ms))
                begin
                    tap_armed[e] = 1'b0;
                    fired = 1'b1;
                    g = tgc_pkg::GEST_TAP;
                end
                if (fired)
                begin
                    w.electrode = EL_W'(e);
                    w.gesture = g;
                    w.last_event = 1'b0;
                    expected_words.push_back(w);
                    count++;
                end
            end
            if (count > 0)
            begin
                w = expected_words.pop_back();
                w.last_event = 1'b1;
                expected_words.push_back(w);
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(gesture_word_t got);
            gesture_word_t want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected word: electrode %0d gesture %0d last %0d",
                                 got.electrode, got.gesture, got.last_event));
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
                report($sformatf({"mismatch: expected electrode %0d gesture %0d last %0d,",
                                  " got electrode %0d gesture %0d last %0d"},
                                 want.electrode, want.gesture, want.last_event,
                                 got.electrode, got.gesture, got.last_event));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [NUM_EL-1:0]   touch_mask;
    logic [T_BITS-1:0]   time_ms;
    logic                out_valid;
    logic                out_ready;
    logic [EL_W-1:0]     electrode;
    logic [GEST_W-1:0]   gesture;
    logic                last_event;

    bit                  calm;
    int unsigned         idle_cycles = 0;
    gesture_board        board;

    touch_gesture_classifier #(
        .NUM_ELECTRODES(NUM_EL),
        .TIME_BITS(T_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .touch_mask(touch_mask),
        .time_ms(time_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .electrode(electrode),
        .gesture(gesture),
        .last_event(last_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: check every accepted word, stall at random unless calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                board.check_result(gesture_word_t'({electrode, gesture, last_event}));
            out_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_poll(logic [NUM_EL-1:0] mask, logic [T_BITS-1:0] t);
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        touch_mask <= mask;
        time_ms <= t;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_poll(mask, t);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timing(logic [CFG_W-1:0] lp, logic [CFG_W-1:0] dc);
        cfg_we <= 1'b1;
        cfg_index <= tgc_pkg::REG_LONG_PRESS;
        cfg_data <= lp;
        @(posedge clk);
        cfg_index <= tgc_pkg::REG_DOUBLE_CLICK;
        cfg_data <= dc;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(tgc_pkg::REG_LONG_PRESS, lp);
        board.set_reg(tgc_pkg::REG_DOUBLE_CLICK, dc);
    endtask

    // random walk of masks and times scaled to the current hold and window
    task automatic random_polls(int count);
        logic [T_BITS-1:0] now;
        logic [NUM_EL-1:0] mask;
        int unsigned       lp;
        int unsigned       dc;
        int unsigned       lo;
        int unsigned       r;
        now = $urandom;
        mask = '0;
        lp = 32'(board.hold_ms);
        dc = 32'(board.window_ms);
        lo = (lp > 2) ? lp - 2 : 0;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                now = $urandom;
            else if (r < 35)
                now = now + $urandom_range(dc + 1, 0);
            else if (r < 70)
                now = now + $urandom_range(lp + 2, lo);
            else
                now = now + $urandom_range(2 * (lp + dc) + 2, 0);
            if ($urandom_range(0, 99) < 15)
                mask = NUM_EL'($urandom);
            else
                for (int e = 0; e < NUM_EL; e++)
                    if ($urandom_range(0, 99) < 30)
                        mask[e] = ~mask[e];
            send_poll(mask, now);
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        calm = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= tgc_pkg::REG_LONG_PRESS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        touch_mask <= '0;
        time_ms <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: long press, double click, tap, window edge, wrap
        send_poll(6'h00, 32'd0);
        send_poll(6'h3F, 32'd100);
        send_poll(6'h3F, 32'd1100);
        send_poll(6'h00, 32'd1200);
        send_poll(6'h01, 32'd2000);
        send_poll(6'h00, 32'd2100);
        send_poll(6'h01, 32'd2200);
        send_poll(6'h00, 32'd2250);
        send_poll(6'h02, 32'd3000);
        send_poll(6'h00, 32'd3050);
        send_poll(6'h00, 32'd3351);
        send_poll(6'h04, 32'd4000);
        send_poll(6'h00, 32'd4010);
        send_poll(6'h04, 32'd4310);
        send_poll(6'h00, 32'd4610);
        send_poll(6'h00, 32'd4911);
        send_poll(6'h08, 32'd5000);
        send_poll(6'h00, 32'd5100);
        send_poll(6'h08, 32'd5200);
        send_poll(6'h08, 32'd6200);
        send_poll(6'h00, 32'd6300);
        send_poll(6'h10, 32'hFFFF_FF00);
        send_poll(6'h10, 32'hFFFF_FFFF);
        send_poll(6'h00, 32'hFFFF_FFFF);
        send_poll(6'h20, 32'h0000_0140);
        random_polls(15);

        // zero hold and zero window
        settle();
        set_timing(16'd0, 16'd0);
        send_poll(6'h3F, 32'h1234_5678);
        send_poll(6'h00, 32'h1234_5678);
        random_polls(15);

        // zero window: double click only at the very same time value
        settle();
        set_timing(16'd1, 16'd0);
        send_poll(6'h01, 32'h8000_0000);
        send_poll(6'h00, 32'h8000_0000);
        send_poll(6'h01, 32'h8000_0000);
        send_poll(6'h00, 32'h8000_0000);
        send_poll(6'h01, 32'h8000_0000);
        send_poll(6'h00, 32'h8000_0000);
        send_poll(6'h00, 32'h8000_0001);
        random_polls(15);

        // widest settings, no idling on either side
        settle();
        calm = 1'b1;
        set_timing(16'hFFFF, 16'hFFFF);
        send_poll(6'h2A, 32'h0000_1000);
        send_poll(6'h2A, 32'h0001_0FFF);
        random_polls(25);
        settle();
        calm = 1'b0;

        set_timing(16'd1, 16'd1);
        random_polls(20);

        for (int k = 0; k < 2; k++)
        begin
            settle();
            set_timing(CFG_W'($urandom_range(2000, 1)), CFG_W'($urandom_range(600, 1)));
            random_polls(20);
        end

        settle();
        if (board.mismatches == 0 && board.expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
